@@ src/srb_pkg.sv @@
// Shared types, widths and codes for the sequence reorder buffer.
`timescale 1ns / 1ps
`default_nettype none

package srb_pkg;

  localparam int SLOTS  = 32;
  localparam int SEQ_W  = 10;
  localparam int PAY_W  = 32;
  localparam int STAT_W = 3;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_BYE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_DELIVERED = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_BUFFERED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLOSED    = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_DRAIN = 1'b1
  } state_t;

  // Broadcast from the controller to every cell of the slot row.
  typedef struct packed {
    logic [SEQ_W-1:0] key_a;      // number to look up, fetch and possibly free
    logic [SEQ_W-1:0] key_b;      // number to probe for presence only
    logic             wr_req;     // store into the lowest empty slot
    logic             clr_req;    // free the slot that matches key_a
    logic [SEQ_W-1:0] wr_seq;
    logic [PAY_W-1:0] wr_payload;
  } ctl_t;

  // Signals rippled from one cell to the next; the last one is the row status.
  typedef struct packed {
    logic             free_found; // an empty slot exists at or below this cell
    logic             hit_a;
    logic             hit_b;
    logic [PAY_W-1:0] pay;        // payload of the slot that matches key_a
  } link_t;

endpackage

`default_nettype wire

@@ src/srb_cell.sv @@
// One slot of the reorder table: holds a number and a payload word.
`timescale 1ns / 1ps
`default_nettype none

module srb_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire srb_pkg::ctl_t  ctl,
  input  wire srb_pkg::link_t link_in,
  output srb_pkg::link_t     link_out
);

  logic [srb_pkg::SEQ_W-1:0] seq_r, seq_nxt;
  logic [srb_pkg::PAY_W-1:0] pay_r;
  logic occ, m_a, m_b, take;

  // A number of zero marks the slot as empty.
  assign occ  = (seq_r != '0);
  assign m_a  = occ && (seq_r == ctl.key_a);
  assign m_b  = occ && (seq_r == ctl.key_b);
  assign take = ctl.wr_req && !occ && !link_in.free_found;

  always_comb begin
    link_out.free_found = link_in.free_found | !occ;
    link_out.hit_a      = link_in.hit_a | m_a;
    link_out.hit_b      = link_in.hit_b | m_b;
    link_out.pay        = link_in.pay | (m_a ? pay_r : '0);
  end

  always_comb begin
    seq_nxt = seq_r;
    if (take) begin
      seq_nxt = ctl.wr_seq;
    end else if (ctl.clr_req && m_a) begin
      seq_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pay_r <= ctl.wr_payload;
    end
  end

endmodule

`default_nettype wire

@@ src/srb_chain.sv @@
// Row of slot cells linked in priority order, lowest slot first.
`timescale 1ns / 1ps
`default_nettype none

module srb_chain (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire srb_pkg::ctl_t ctl,
  output srb_pkg::link_t     stat
);

  srb_pkg::link_t link [0:srb_pkg::SLOTS];

  assign link[0] = '0;

  for (genvar g = 0; g < srb_pkg::SLOTS; g++) begin : g_cell
    srb_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .link_in  (link[g]),
      .link_out (link[g+1])
    );
  end

  assign stat = link[srb_pkg::SLOTS];

endmodule

`default_nettype wire

@@ src/sequence_reorder_buffer_core.sv @@
// Top level of the sequence reorder buffer: controller, slot row and output register.
// The first result word is registered: it appears in the cycle after the input word is accepted.
// A delivery that releases buffered successors is followed by their result words, one
// result per cycle while the receiver does not stall, set by the drain sequencer that
// frees one slot per result word. Reset clears the last delivered number and every
// slot number at once; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sequence_reorder_buffer_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic                         in_opcode,
  input  wire logic [srb_pkg::SEQ_W-1:0]    in_seq_number,
  input  wire logic [srb_pkg::PAY_W-1:0]    in_payload,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [srb_pkg::STAT_W-1:0]   out_status,
  output      logic [srb_pkg::SEQ_W-1:0]    out_seq,
  output      logic [srb_pkg::PAY_W-1:0]    out_payload,
  output      logic                         out_last
);

  srb_pkg::state_t           state_r, state_nxt;
  logic [srb_pkg::SEQ_W-1:0] ld_r, ld_nxt;     // number last delivered
  logic [srb_pkg::SEQ_W-1:0] expect_num;

  logic                      out_valid_r;
  srb_pkg::status_t          out_status_r, status_nxt;
  logic [srb_pkg::SEQ_W-1:0] out_seq_r, seq_nxt;
  logic [srb_pkg::PAY_W-1:0] out_payload_r, payload_nxt;
  logic                      out_last_r, last_nxt;
  logic                      load;

  logic                      out_free;
  logic                      in_acc;

  srb_pkg::ctl_t             ctl;
  srb_pkg::link_t            stat;

  // The output register can take a new word when it is empty or being drained.
  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = !((state_r == srb_pkg::S_IDLE) && out_free);
  assign in_acc     = in_valid && !in_stall;
  assign expect_num = ld_r + 1'b1;

  srb_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .stat  (stat)
  );

  // While idle, key A is the arriving number (duplicate check and lookup) and key B
  // its successor, probed to learn whether a drain follows the delivery. While
  // draining, key A is the slot to release now and key B the one after it, so the
  // last flag of every result word is known when the word is loaded. A key that
  // wraps to zero never matches, since zero marks an empty slot; this ends a drain
  // at the wrap just as the sequence space requires.
  always_comb begin
    ctl            = '0;
    ctl.wr_seq     = in_seq_number;
    ctl.wr_payload = in_payload;
    if (state_r == srb_pkg::S_IDLE) begin
      ctl.key_a = in_seq_number;
      ctl.key_b = in_seq_number + 1'b1;
    end else begin
      ctl.key_a = ld_r + 1'b1;
      ctl.key_b = ld_r + 2'd2;
    end

    state_nxt   = state_r;
    ld_nxt      = ld_r;
    load        = 1'b0;
    status_nxt  = srb_pkg::ST_DUPLICATE;
    seq_nxt     = in_seq_number;
    payload_nxt = '0;
    last_nxt    = 1'b1;

    case (state_r)
      srb_pkg::S_IDLE: begin
        if (in_acc) begin
          load = 1'b1;
          if (in_opcode == srb_pkg::OP_BYE) begin
            // A bye only reports; the table is untouched.
            status_nxt = srb_pkg::ST_CLOSED;
          end else if (in_seq_number == expect_num) begin
            status_nxt  = srb_pkg::ST_DELIVERED;
            payload_nxt = in_payload;
            ld_nxt      = in_seq_number;
            last_nxt    = !stat.hit_b;
            if (stat.hit_b) begin
              state_nxt = srb_pkg::S_DRAIN;
            end
          end else if (in_seq_number > expect_num) begin
            if (stat.hit_a) begin
              status_nxt = srb_pkg::ST_DUPLICATE;
            end else if (stat.free_found) begin
              // The lowest empty cell claims the word through the row's priority link.
              ctl.wr_req = 1'b1;
              status_nxt = srb_pkg::ST_BUFFERED;
            end else begin
              status_nxt = srb_pkg::ST_FULL;
            end
          end else begin
            // An older number was delivered already.
            status_nxt = srb_pkg::ST_DUPLICATE;
          end
        end
      end
      srb_pkg::S_DRAIN: begin
        if (out_free) begin
          // Key A is known to be buffered: the previous step probed it.
          load        = 1'b1;
          ctl.clr_req = 1'b1;
          status_nxt  = srb_pkg::ST_DELIVERED;
          seq_nxt     = ctl.key_a;
          payload_nxt = stat.pay;
          ld_nxt      = ctl.key_a;
          last_nxt    = !stat.hit_b;
          if (!stat.hit_b) begin
            state_nxt = srb_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = srb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srb_pkg::S_IDLE;
      ld_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ld_r        <= ld_nxt;
      out_valid_r <= load || (out_valid_r && out_stall);
    end
  end

  // The result payload registers hold their word until a new one is loaded.
  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r  <= status_nxt;
      out_seq_r     <= seq_nxt;
      out_payload_r <= payload_nxt;
      out_last_r    <= last_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_seq     = out_seq_r;
  assign out_payload = out_payload_r;
  assign out_last    = out_last_r;

  // A drain is only entered by loading a result word, and it stays loaded until
  // the drain has emitted its last word.
  a_drain_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == srb_pkg::S_DRAIN |-> out_valid_r)
    else $error("drain active without a pending result word");

  // No new input is taken while buffered words are still being released.
  a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == srb_pkg::S_DRAIN |-> in_stall)
    else $error("input accepted during a drain");

  // A bye produces exactly one closing word, flagged as the last.
  a_bye_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_opcode == srb_pkg::OP_BYE |=>
      out_valid_r && out_last_r && out_status_r == srb_pkg::ST_CLOSED &&
      state_r == srb_pkg::S_IDLE)
    else $error("bye did not produce a single closing word");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the sequence reorder buffer core, with directed and random traffic.
`timescale 1ns / 1ps

module testbench;
  import srb_pkg::*;

  // Cycles with no word accepted on either side before the run is declared hung.
  localparam int STUCK_LIMIT = 2000;
  // Random traffic stops once this many words have gone in.
  localparam int ITEM_TARGET = 380;
  localparam int PHASE_ITEMS = 127;
  localparam int SETTLE_CYCLES = 20;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [PAY_W-1:0] pay_t;

  typedef struct {
    status_t status;
    seq_t    seq;
    pay_t    payload;
    logic    last;
  } result_word_t;

  typedef enum int {
    NOISE_BYE,
    NOISE_OLD,
    NOISE_ANY,
    NOISE_AHEAD
  } noise_t;

  // Tracks the delivery state of the block and the result words it still owes.
  class reorder_tracker;
    seq_t         last_delivered;
    seq_t         slot_seq[SLOTS];
    pay_t         slot_payload[SLOTS];
    result_word_t awaited[$];
    int           fail_count;

    function new();
      last_delivered = '0;
      foreach (slot_seq[i]) begin
        slot_seq[i] = '0;
        slot_payload[i] = '0;
      end
      fail_count = 0;
    endfunction

    // The number after 1023 is 0, so the sum is kept at the sequence width.
    function seq_t next_number();
      return last_delivered + 1'b1;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function int find_slot(seq_t key);
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_seq[i] == key) return i;
      end
      return -1;
    endfunction

    function void add(status_t st, seq_t seq, pay_t pay);
      result_word_t r;
      r.status = st;
      r.seq = seq;
      r.payload = pay;
      r.last = 1'b0;
      awaited.push_back(r);
    endfunction

    // Works out every result word that one accepted input word causes.
    function void note_word(logic op, seq_t seq, pay_t pay);
      seq_t         want;
      int           s;
      int           drained;
      result_word_t r;
      want = next_number();
      if (op == OP_BYE) begin
        add(ST_CLOSED, seq, '0);
      end else if (seq == want) begin
        add(ST_DELIVERED, seq, pay);
        last_delivered = seq;
        drained = 0;
        // Buffered successors follow one by one, each freeing its slot.
        while (drained < SLOTS) begin
          want = next_number();
          if (want == '0) break;
          s = find_slot(want);
          if (s < 0) break;
          add(ST_DELIVERED, want, slot_payload[s]);
          slot_seq[s] = '0;
          last_delivered = want;
          drained++;
        end
      end else if (seq > want) begin
        if (find_slot(seq) >= 0) begin
          add(ST_DUPLICATE, seq, '0);
        end else begin
          s = find_slot('0);
          if (s < 0) begin
            add(ST_FULL, seq, '0);
          end else begin
            slot_seq[s] = seq;
            slot_payload[s] = pay;
            add(ST_BUFFERED, seq, '0);
          end
        end
      end else begin
        add(ST_DUPLICATE, seq, '0);
      end
      r = awaited.pop_back();
      r.last = 1'b1;
      awaited.push_back(r);
    endfunction

    function bit field_ok(string field, logic [PAY_W-1:0] want, logic [PAY_W-1:0] got);
      if (want === got) return 1'b1;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      return 1'b0;
    endfunction

    function void check_word(logic [STAT_W-1:0] st, seq_t seq, pay_t pay, logic last);
      result_word_t r;
      bit           ok;
      if (awaited.size() == 0) begin
        $error("result word with nothing awaited: status %0d, seq %0d", st, seq);
        fail_count++;
        return;
      end
      r = awaited.pop_front();
      ok = field_ok("status", r.status, st);
      ok = field_ok("out_seq", r.seq, seq) && ok;
      ok = field_ok("out_payload", r.payload, pay) && ok;
      ok = field_ok("last", r.last, last) && ok;
      if (!ok) fail_count++;
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_opcode;
  seq_t                in_seq_number;
  pay_t                in_payload;
  logic                out_valid;
  logic                out_stall;
  logic [STAT_W-1:0]   out_status;
  seq_t                out_seq;
  pay_t                out_payload;
  logic                out_last;

  int send_idle_pct = 15;
  int recv_stall_pct = 81;
  int items_sent = 0;
  int stuck_cycles = 0;

  reorder_tracker tracker;

  sequence_reorder_buffer_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_seq_number (in_seq_number),
    .in_payload    (in_payload),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_seq       (out_seq),
    .out_payload   (out_payload),
    .out_last      (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver stalls at random, at a rate set by the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      tracker.check_word(out_status, out_seq, out_payload, out_last);
    end
  end

  // Ends the run if neither side moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("sequence_reorder_buffer_core: mismatch");
        $finish;
      end
    end
  end

  // Offers one word, after an optional random gap, and holds it until it is taken.
  task automatic send_word(logic op, seq_t seq, pay_t pay);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_seq_number <= seq;
    in_payload <= pay;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_word(op, seq, pay);
    items_sent++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  // A stray word: a bye, an old number, any number, or one a little ahead.
  task automatic send_noise();
    seq_t   want;
    noise_t pick;
    int     n;
    want = tracker.next_number();
    pick = noise_t'($urandom_range(0, 3));
    case (pick)
      NOISE_BYE: begin
        send_word(OP_BYE, seq_t'($urandom_range(0, 1023)), $urandom());
      end
      NOISE_OLD: begin
        n = (want == '0) ? $urandom_range(0, 1023) : $urandom_range(0, int'(want) - 1);
        send_word(OP_DATA, seq_t'(n), $urandom());
      end
      NOISE_ANY: begin
        send_word(OP_DATA, seq_t'($urandom_range(0, 1023)), $urandom());
      end
      default: begin
        n = int'(want) + $urandom_range(1, 40);
        if (n > 1023) n = 1023;
        send_word(OP_DATA, seq_t'(n), $urandom());
      end
    endcase
  endtask

  // Sends a run of consecutive numbers starting at the next expected one, in shuffled
  // order, with a few stray words mixed in. Long runs overflow the slot table.
  task automatic send_window();
    int order[64];
    int base;
    int span;
    int j;
    int k;
    int tmp;
    base = int'(tracker.next_number());
    if ($urandom_range(0, 9) == 0) span = $urandom_range(30, 40);
    else span = $urandom_range(1, 10);
    if (base + span > 1024) span = 1024 - base;
    for (j = 0; j < span; j++) order[j] = base + j;
    for (j = span - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      tmp = order[j];
      order[j] = order[k];
      order[k] = tmp;
    end
    // Holding the expected number back to the end makes the whole run get
    // buffered first and then drain as one long burst.
    if ($urandom_range(0, 9) < 4) begin
      for (j = 0; j < span - 1; j++) begin
        if (order[j] == base) begin
          order[j] = order[span - 1];
          order[span - 1] = base;
        end
      end
    end
    for (j = 0; j < span; j++) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      send_word(OP_DATA, seq_t'(order[j]), $urandom());
    end
  endtask

  initial begin
    int phase;
    int cur_phase;
    tracker = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_DATA;
    in_seq_number = '0;
    in_payload = '0;
    out_stall = 1'b0;
    cur_phase = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Byes at the number extremes, then zero, a duplicate, then 1, which is delivered, and 1 again, a duplicate.
    send_word(OP_BYE, 10'd0, 32'hFFFF_FFFF);
    send_word(OP_BYE, 10'd1023, 32'h0000_0000);
    send_word(OP_DATA, 10'd0, 32'hDEAD_BEEF);
    send_word(OP_DATA, 10'd1, 32'hFFFF_FFFF);
    send_word(OP_DATA, 10'd1, 32'h0000_0000);
    // The top number stays in a slot for the rest of the run; sending it again
    // is a duplicate of a buffered number.
    send_word(OP_DATA, 10'd1023, 32'hA5A5_A5A5);
    send_word(OP_DATA, 10'd1023, 32'h0000_0000);
    send_word(OP_DATA, 10'd4, 32'h0000_0000);
    send_word(OP_DATA, 10'd3, 32'hFFFF_FFFF);
    send_word(OP_DATA, 10'd6, 32'h5A5A_5A5A);
    // Delivering 2 releases 3 and 4; a bye in between leaves the state alone.
    send_word(OP_DATA, 10'd2, 32'h1234_5678);
    send_word(OP_BYE, 10'd5, 32'h0F0F_0F0F);
    send_word(OP_DATA, 10'd5, 32'h0000_0001);
    send_word(OP_DATA, 10'd6, 32'h8000_0000);
    send_word(OP_DATA, 10'd512, 32'h8000_0000);
    send_word(OP_DATA, 10'd7, 32'h7FFF_FFFF);
    hold_until_drained();

    // Random traffic in three phases of idling until the word budget is spent.
    while (items_sent < ITEM_TARGET) begin
      phase = items_sent / PHASE_ITEMS;
      if (phase > 2) phase = 2;
      if (phase != cur_phase) begin
        hold_until_drained();
        cur_phase = phase;
        if (phase == 1) begin
          send_idle_pct = 81;
          recv_stall_pct = 15;
        end else begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      end
      send_window();
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.fail_count == 0) begin
      $display("sequence_reorder_buffer_core: match");
    end else begin
      $display("sequence_reorder_buffer_core: mismatch");
    end
    $finish;
  end

endmodule
